// ===== rtl/core/lgf_pkg.sv =====
// ----------------------------------------------------------------------------
// lgf_pkg
// Shared widths and constants of the line gap linear fill unit.
// ----------------------------------------------------------------------------
package lgf_pkg;

	localparam int POS_W           = 6;
	localparam int VAL_W           = 8;
	localparam int LINE_LENGTH_DEF = 64;
	localparam int MIN_GAP         = 2;

	// |value difference| * offset stays below 255 * 63
	localparam int DIVIDEND_W = 14;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [VAL_W-1:0]      val_t;
	typedef logic [DIVIDEND_W-1:0] dividend_t;

endpackage

// ===== rtl/core/lgf_point_if.sv =====
// ----------------------------------------------------------------------------
// lgf_point_if
// Input channel: one nonzero sample point of a voxel line per transfer.
// ----------------------------------------------------------------------------
interface lgf_point_if;
	import lgf_pkg::*;

	logic valid;
	logic ready;
	pos_t point_position;
	val_t point_value;
	logic line_start;

	modport source (output valid, output point_position, output point_value,
		output line_start, input ready);
	modport sink (input valid, input point_position, input point_value,
		input line_start, output ready);

endinterface

// ===== rtl/core/lgf_fill_if.sv =====
// ----------------------------------------------------------------------------
// lgf_fill_if
// Output channel: one interpolated sample of a gap per transfer.
// ----------------------------------------------------------------------------
interface lgf_fill_if;
	import lgf_pkg::*;

	logic valid;
	logic ready;
	pos_t fill_position;
	val_t fill_value;
	logic last_fill;

	modport source (output valid, output fill_position, output fill_value,
		output last_fill, input ready);
	modport sink (input valid, input fill_position, input fill_value,
		input last_fill, output ready);

endinterface

// ===== rtl/core/lgf_div.sv =====
// ----------------------------------------------------------------------------
// lgf_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lgf_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  lgf_pkg::dividend_t       dividend,
	input  lgf_pkg::pos_t            divisor,
	output logic                     done,
	output lgf_pkg::dividend_t       quotient
);
	import lgf_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     rem_q;
	dividend_t            work_q;
	pos_t                 divisor_q;
	logic                 done_q;

	logic [POS_W:0]       trial;
	logic                 fits;
	logic [POS_W:0]       trial_sub;

	// trial subtract of the divisor from the partial remainder
	always_comb begin
		trial     = {rem_q, work_q[DIVIDEND_W-1]};
		fits      = trial >= {1'b0, divisor_q};
		trial_sub = trial - {1'b0, divisor_q};
	end

	// step through the quotient bits, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: remainder and shifting dividend/quotient word
	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
			work_q <= {work_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ===== rtl/core/line_gap_linear_fill_unit.sv =====
// ----------------------------------------------------------------------------
// line_gap_linear_fill_unit
// Linear filling of the gaps between nonzero samples of a voxel line.
// ----------------------------------------------------------------------------
// Usage:
//   point : sample points (position, value, line_start) in rising position
//           order. A point with line_start set opens a new line.
//   fill  : one transfer for each position strictly between the previous and
//           the new point when they lie two or more apart; last_fill marks
//           the final sample of a gap.
//   Points at or beyond LINE_LENGTH are taken and dropped without effect.
//   Every filled sample runs one pass of a shared 14-step restoring divider:
//   a start state, the divider pass and an output state in which the sample
//   is on offer; the next sample's division begins only once the offered
//   sample has been taken.
//   A point that fills nothing is stored without leaving the idle state.
//   point.ready is low from the acceptance of a filling point until its last
//   sample has been transferred. A stalled receiver holds the offered sample
//   steady and the unit simply waits.
//   Reset clears the held previous point; the next point only gets stored.
// ----------------------------------------------------------------------------
module line_gap_linear_fill_unit #(
	parameter int LINE_LENGTH = lgf_pkg::LINE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lgf_point_if.sink  point,
	lgf_fill_if.source fill
);
	import lgf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t    state_q;
	logic      have_q;
	pos_t      prev_pos_q;
	val_t      prev_val_q;

	// working copies of the gap under fill
	val_t      base_val_q;
	pos_t      cur_pos_q;
	pos_t      end_pos_q;
	pos_t      gap_q;
	val_t      dmag_q;
	logic      dneg_q;
	dividend_t acc_q;

	pos_t      fill_pos_q;
	val_t      fill_val_q;
	logic      fill_last_q;

	logic      div_done;
	dividend_t div_quo;

	logic      in_line;
	logic      do_fill;
	logic      is_last;
	val_t      quo_val;
	logic [VAL_W:0] diff_raw;

	// decode the incoming point
	always_comb begin
		in_line  = {1'b0, point.point_position} < (POS_W + 1)'(LINE_LENGTH);
		do_fill  = in_line && !point.line_start && have_q &&
			({1'b0, point.point_position} >= ({1'b0, prev_pos_q} + (POS_W + 1)'(MIN_GAP)));
		diff_raw = {1'b0, point.point_value} - {1'b0, prev_val_q};
		is_last  = (cur_pos_q + 1'b1) == end_pos_q;
		quo_val  = div_quo[VAL_W-1:0];
	end

	assign point.ready = (state_q == ST_IDLE);

	// sequencer with previous point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			have_q     <= 1'b0;
			prev_pos_q <= '0;
			prev_val_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (point.valid && in_line) begin
						have_q     <= 1'b1;
						prev_pos_q <= point.point_position;
						prev_val_q <= point.point_value;
						if (do_fill) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (fill.ready) begin
						state_q <= is_last ? ST_IDLE : ST_START;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// gap working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && point.valid && do_fill) begin
			base_val_q <= prev_val_q;
			cur_pos_q  <= prev_pos_q + 1'b1;
			end_pos_q  <= point.point_position;
			gap_q      <= point.point_position - prev_pos_q;
			dneg_q     <= diff_raw[VAL_W];
			dmag_q     <= diff_raw[VAL_W] ? VAL_W'(-diff_raw) : diff_raw[VAL_W-1:0];
			acc_q      <= DIVIDEND_W'(diff_raw[VAL_W] ? VAL_W'(-diff_raw)
				: diff_raw[VAL_W-1:0]);
		end else if (state_q == ST_OUT && fill.ready && !is_last) begin
			cur_pos_q <= cur_pos_q + 1'b1;
			acc_q     <= acc_q + DIVIDEND_W'(dmag_q);
		end
	end

	// latch the finished sample
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			fill_pos_q  <= cur_pos_q;
			fill_val_q  <= dneg_q ? (base_val_q - quo_val) : (base_val_q + quo_val);
			fill_last_q <= is_last;
		end
	end

	lgf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (acc_q),
		.divisor  (gap_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign fill.valid         = (state_q == ST_OUT);
	assign fill.fill_position = fill_pos_q;
	assign fill.fill_value    = fill_val_q;
	assign fill.last_fill     = fill_last_q;

endmodule
